[hdl/midpoint_line_rasterizer_defines.svh]
// Assertion macros shared by the midpoint line rasterizer RTL.
// No dependencies; files that assert include this header by name.
`ifndef MIDPOINT_LINE_RASTERIZER_DEFINES_SVH
`define MIDPOINT_LINE_RASTERIZER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising clock edge outside reset.
`define MLR_ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define MLR_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed: next-cycle implication");

`else

`define MLR_ASSERT_IMPLY(label, clk, rst, lhs, rhs)
`define MLR_ASSERT_NEXT(label, clk, rst, lhs, rhs)

`endif

`endif

[hdl/mlr_pkg.sv]
// Shared types and constants for the midpoint line rasterizer.
// No dependencies; used by every module of the block.
package mlr_pkg;

   localparam int COORD_W         = 6;
   localparam int DEC_W           = COORD_W + 3;
   localparam int COORD_BITS_DEF  = 6;
   localparam int QUEUE_DEPTH_DEF = 2;

   typedef struct packed {
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] start_y;
      logic [COORD_W-1:0] end_x;
      logic [COORD_W-1:0] end_y;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
      logic               last_pixel;
      logic               unsupported;
   } rsp_type;

   typedef enum logic [1:0] {
      MODE_POINT_UNSUP,
      MODE_POINT,
      MODE_VERTICAL,
      MODE_SLOPE
   } mode_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   // One classified line command, as it sits in the queue.
   typedef struct packed {
      mode_type                  mode;
      logic [COORD_W-1:0]        start_x;
      logic [COORD_W-1:0]        start_y;
      logic [COORD_W-1:0]        end_x;
      logic [COORD_W-1:0]        end_y;
      logic signed [DEC_W-1:0]   dec_init;
      logic signed [DEC_W-1:0]   inc_flat;
      logic signed [DEC_W-1:0]   inc_diag;
   } cmd_type;

   // Head of the queue as seen by the walker.
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } qhead_type;

endpackage

[hdl/mlr_front.sv]
// Front end: takes a line word and classifies it into a walk command.
// Depends on mlr_pkg.
module mlr_front #(
   parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
   input  logic              req_valid,
   output logic              req_ready,
   input  mlr_pkg::req_type  req_data,
   output logic              push_valid,
   input  logic              push_ready,
   output mlr_pkg::cmd_type  push_cmd
);

   localparam int CW    = mlr_pkg::COORD_W;
   localparam int DW    = COORD_BITS + 3;
   localparam int DEC_W = mlr_pkg::DEC_W;

   logic [COORD_BITS-1:0]     sx, sy, ex, ey;
   logic signed [COORD_BITS:0] dx, dy;
   logic signed [DW-1:0]      two_dx, two_dy, dec0, diag;
   logic                      dx_zero, octant;

   always_comb begin
      sx = req_data.start_x[COORD_BITS-1:0];
      sy = req_data.start_y[COORD_BITS-1:0];
      ex = req_data.end_x[COORD_BITS-1:0];
      ey = req_data.end_y[COORD_BITS-1:0];

      dx = $signed({1'b0, ex}) - $signed({1'b0, sx});
      dy = $signed({1'b0, ey}) - $signed({1'b0, sy});

      two_dx = $signed({dx[COORD_BITS], dx, 1'b0});
      two_dy = $signed({dy[COORD_BITS], dy, 1'b0});
      dec0   = two_dy - DW'(dx);
      diag   = two_dy - two_dx;

      dx_zero = (dx == '0);
      octant  = !dx[COORD_BITS] && !dx_zero && !dy[COORD_BITS] && (dy <= dx);

      push_cmd.start_x  = CW'(sx);
      push_cmd.start_y  = CW'(sy);
      push_cmd.end_x    = CW'(ex);
      push_cmd.end_y    = CW'(ey);
      push_cmd.dec_init = DEC_W'(dec0);
      push_cmd.inc_flat = DEC_W'(two_dy);
      push_cmd.inc_diag = DEC_W'(diag);

      // Vertical lines only walk upward; a downward or empty one is a single point.
      if (dx_zero) begin
         push_cmd.mode = (!dy[COORD_BITS] && (dy != '0)) ? mlr_pkg::MODE_VERTICAL
                                                          : mlr_pkg::MODE_POINT;
      end else if (octant) begin
         push_cmd.mode = mlr_pkg::MODE_SLOPE;
      end else begin
         push_cmd.mode = mlr_pkg::MODE_POINT_UNSUP;
      end
   end

   assign push_valid = req_valid;
   assign req_ready  = push_ready;

endmodule

[hdl/mlr_queue.sv]
// Short command queue between the front end and the walker.
// Depends on mlr_pkg.
module mlr_queue #(
   parameter int DEPTH = mlr_pkg::QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  mlr_pkg::cmd_type   push_cmd,
   output mlr_pkg::qhead_type head,
   input  logic               pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   mlr_pkg::cmd_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   always_comb begin
      push_ready = (count_ff != FULL_CNT);
      do_push    = push_valid && push_ready;
      head.valid = (count_ff != '0);
      head.cmd   = entry_ff[rd_ptr_ff];
      do_pop     = pop && head.valid;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[hdl/mlr_walker.sv]
// Back end: walks one command pixel by pixel into the output register.
// Depends on mlr_pkg.
module mlr_walker #(
   parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  mlr_pkg::qhead_type head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output mlr_pkg::rsp_type   rsp_data
);

   localparam int CW = mlr_pkg::COORD_W;
   localparam int DW = COORD_BITS + 3;

   mlr_pkg::state_type state_ff, state_in;
   mlr_pkg::mode_type  mode_ff, mode_in;
   logic [COORD_BITS-1:0] cx_ff, cx_in, cy_ff, cy_in, tx_ff, tx_in, ty_ff, ty_in;
   logic signed [DW-1:0]  dec_ff, dec_in, flat_ff, flat_in, diag_ff, diag_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   mlr_pkg::rsp_type      rsp_data_ff, rsp_data_in;
   logic                  load, emit, done;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mlr_pkg::ST_IDLE: begin
            if (head.valid) begin
               state_in = mlr_pkg::ST_RUN;
            end
         end
         mlr_pkg::ST_RUN: begin
            if (emit && done) begin
               state_in = mlr_pkg::ST_IDLE;
            end
         end
         default: state_in = mlr_pkg::ST_IDLE;
      endcase
   end

   // Control outputs of the state machine.
   always_comb begin
      load = 1'b0;
      emit = 1'b0;
      unique case (state_ff)
         mlr_pkg::ST_IDLE: load = head.valid;
         mlr_pkg::ST_RUN:  emit = !rsp_valid_ff || rsp_ready;
         default: begin
            load = 1'b0;
            emit = 1'b0;
         end
      endcase
   end

   assign pop = load;

   always_comb begin
      unique case (mode_ff)
         mlr_pkg::MODE_VERTICAL: done = (cy_ff == ty_ff);
         mlr_pkg::MODE_SLOPE:    done = (cx_ff == tx_ff);
         default:                done = 1'b1;
      endcase
   end

   // Datapath: load a command, or step the walk after each emitted pixel.
   always_comb begin
      mode_in = mode_ff;
      cx_in   = cx_ff;
      cy_in   = cy_ff;
      tx_in   = tx_ff;
      ty_in   = ty_ff;
      dec_in  = dec_ff;
      flat_in = flat_ff;
      diag_in = diag_ff;

      if (load) begin
         mode_in = head.cmd.mode;
         cx_in   = head.cmd.start_x[COORD_BITS-1:0];
         cy_in   = head.cmd.start_y[COORD_BITS-1:0];
         tx_in   = head.cmd.end_x[COORD_BITS-1:0];
         ty_in   = head.cmd.end_y[COORD_BITS-1:0];
         dec_in  = head.cmd.dec_init[DW-1:0];
         flat_in = head.cmd.inc_flat[DW-1:0];
         diag_in = head.cmd.inc_diag[DW-1:0];
      end else if (emit && !done) begin
         if (mode_ff == mlr_pkg::MODE_VERTICAL) begin
            cy_in = cy_ff + 1'b1;
         end else if (dec_ff <= 0) begin
            dec_in = dec_ff + flat_ff;
            cx_in  = cx_ff + 1'b1;
         end else begin
            dec_in = dec_ff + diag_ff;
            cx_in  = cx_ff + 1'b1;
            cy_in  = cy_ff + 1'b1;
         end
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.pixel_x      = CW'(cx_ff);
         rsp_data_in.pixel_y      = CW'(cy_ff);
         rsp_data_in.last_pixel   = done;
         rsp_data_in.unsupported  = (mode_ff == mlr_pkg::MODE_POINT_UNSUP);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mlr_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      tx_ff       <= tx_in;
      ty_ff       <= ty_in;
      dec_ff      <= dec_in;
      flat_ff     <= flat_in;
      diag_ff     <= diag_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[hdl/midpoint_line_rasterizer.sv]
// Top level of the midpoint line rasterizer: front end, queue and walker.
// Depends on mlr_pkg, mlr_front, mlr_queue, mlr_walker and the defines header.
//
// Usage: each word on the req_ channel is one line command (start and end point
// on the grid). For every command the block returns a run of words on the rsp_
// channel, one pixel per word, the final one flagged with last_pixel. A line in
// the first octant walks x from start to end; a vertical line walks y upward.
// Any other line, and a vertical line going down, returns only its start point;
// the non-vertical ones also carry the unsupported flag.
// When the block is idle, an accepted command passes through the queue, then
// the walker registers that it loads into, then the output register. The walker
// loads each command in its idle state and then emits its pixels one by one in
// its run state; that walker loop sets the command rate.
// The queue holds further commands so the input keeps accepting while a run is
// still being walked; req_ready drops only when the queue is full.
// When the receiver stalls (rsp_ready low), the output register holds its word
// and the walker pauses; no pixel is lost or repeated.
// Reset is synchronous and active high: it empties the queue, returns the
// walker to idle and clears rsp_valid.
`include "midpoint_line_rasterizer_defines.svh"

module midpoint_line_rasterizer #(
   parameter int COORD_BITS  = mlr_pkg::COORD_BITS_DEF,
   parameter int QUEUE_DEPTH = mlr_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mlr_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mlr_pkg::rsp_type  rsp_data
);

   logic               push_valid, push_ready, pop;
   mlr_pkg::cmd_type   push_cmd;
   mlr_pkg::qhead_type head;

   // Classifies each incoming word and computes the walk increments.
   mlr_front #(
      .COORD_BITS(COORD_BITS)
   ) u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_cmd  (push_cmd)
   );

   // Decouples command acceptance from the pixel walk.
   mlr_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_cmd  (push_cmd),
      .head      (head),
      .pop       (pop)
   );

   // Walks one command at a time into the registered output.
   mlr_walker #(
      .COORD_BITS(COORD_BITS)
   ) u_walker (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   // An unsupported line is always a single pixel, so its word closes the run.
   `MLR_ASSERT_IMPLY(a_unsup_is_last, clock, reset,
      rsp_valid && rsp_data.unsupported, rsp_data.last_pixel)

   // Within a run the walker refills the output register without a bubble.
   `MLR_ASSERT_NEXT(a_run_no_bubble, clock, reset,
      rsp_valid && rsp_ready && !rsp_data.last_pixel, rsp_valid)

endmodule
